// ===== rtl/prpd_pkg.sv =====
`timescale 1ns / 1ps

package prpd_pkg;

	localparam int PALETTE_ENTRIES = 4096;
	localparam int IDX_W           = $clog2(PALETTE_ENTRIES);

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 72;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_BODY  = 2'd2;

	localparam logic       KIND_RUN   = 1'b0;
	localparam logic       KIND_ERROR = 1'b1;

	localparam logic [7:0]  CODE_SKIP  = 8'hfe;
	localparam logic [23:0] COLOR_SKIP = 24'h0000fe;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_RUN   = 2'd1,
		OP_ERR   = 2'd2
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
		logic fin;
	} stage_t;

	typedef struct packed {
		logic [15:0] run;
		logic [7:0]  code;
	} entry_t;

	function automatic logic [7:0] red_level(input logic [2:0] sel);
		logic [7:0] v;
		case (sel)
			3'd0: v = 8'h00;
			3'd1: v = 8'h24;
			3'd2: v = 8'h49;
			3'd3: v = 8'h6d;
			3'd4: v = 8'h92;
			3'd5: v = 8'hb6;
			3'd6: v = 8'hdb;
			default: v = 8'hff;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] gray_level(input logic [2:0] sel);
		logic [7:0] v;
		case (sel)
			3'd0: v = 8'h00;
			3'd1: v = 8'h24;
			3'd2: v = 8'h49;
			3'd3: v = 8'h6d;
			3'd4: v = 8'h92;
			3'd5: v = 8'hc6;
			3'd6: v = 8'heb;
			default: v = 8'hff;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] gb_level(input logic [1:0] sel);
		logic [7:0] v;
		case (sel)
			2'd0: v = 8'h00;
			2'd1: v = 8'h55;
			2'd2: v = 8'haa;
			default: v = 8'hff;
		endcase
		return v;
	endfunction

	function automatic logic [23:0] color_rom(input logic [7:0] code);
		logic [7:0]  g;
		logic [23:0] c;
		g = gray_level(code[2:0]);
		if (!code[7]) begin
			c = {red_level(code[2:0]), gb_level(code[4:3]), gb_level(code[6:5])};
		end else if (code[6:3] == 4'd0) begin
			c = {g, g, g};
		end else if (code == CODE_SKIP) begin
			c = COLOR_SKIP;
		end else begin
			c = 24'h0000ff;
		end
		return c;
	endfunction

endpackage

// ===== rtl/prpd_front.sv =====
`timescale 1ns / 1ps

module prpd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   req_type,
	input  logic [11:0]                  entry_index,
	input  logic [15:0]                  entry_run,
	input  logic [7:0]                   entry_code,
	input  logic [7:0]                   body_byte,
	input  logic                         final_byte,
	input  logic [12:0]                  palette_size,
	input  logic                         stage_ready,
	output prpd_pkg::stage_t             stage,
	output prpd_pkg::entry_t             entry
);

	prpd_pkg::entry_t mem [prpd_pkg::PALETTE_ENTRIES];

	prpd_pkg::stage_t stage_s1;
	prpd_pkg::entry_t entry_s1;
	logic             pending_q;
	logic [6:0]       high_q;
	logic             error_q;

	logic             accept;
	logic             is_body;
	logic             have_idx;
	logic [14:0]      idx;
	logic             bad_idx;
	logic             trunc;
	logic             push;
	prpd_pkg::op_t    push_op;
	logic             wr_en;

	assign in_ready = !stage_s1.valid || stage_ready;
	assign accept   = in_valid && in_ready;
	assign is_body  = accept && (req_type == prpd_pkg::REQ_BODY) && !error_q;

	always_comb begin
		have_idx = 1'b0;
		trunc    = 1'b0;
		idx      = {7'd0, body_byte};
		if (pending_q) begin
			have_idx = 1'b1;
			idx      = {high_q, body_byte};
		end else if (body_byte[7]) begin
			trunc = final_byte;
		end else begin
			have_idx = 1'b1;
		end
	end

	assign bad_idx = ({1'b0, idx} >= {3'd0, palette_size})
		|| (32'(idx) >= 32'(prpd_pkg::PALETTE_ENTRIES));

	always_comb begin
		push    = 1'b0;
		push_op = prpd_pkg::OP_RUN;
		if (accept && req_type == prpd_pkg::REQ_START) begin
			push    = 1'b1;
			push_op = prpd_pkg::OP_START;
		end else if (is_body && (trunc || (have_idx && bad_idx))) begin
			push    = 1'b1;
			push_op = prpd_pkg::OP_ERR;
		end else if (is_body && have_idx) begin
			push    = 1'b1;
			push_op = prpd_pkg::OP_RUN;
		end
	end

	assign wr_en = accept && (req_type == prpd_pkg::REQ_WRITE)
		&& (32'(entry_index) < 32'(prpd_pkg::PALETTE_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			high_q    <= '0;
			error_q   <= 1'b0;
		end else if (accept) begin
			if (req_type == prpd_pkg::REQ_START) begin
				pending_q <= 1'b0;
				high_q    <= '0;
				error_q   <= 1'b0;
			end else if (req_type == prpd_pkg::REQ_BODY) begin
				if (error_q) begin
					if (final_byte)
						pending_q <= 1'b0;
				end else if (pending_q) begin
					pending_q <= 1'b0;
					if (bad_idx)
						error_q <= 1'b1;
				end else if (body_byte[7]) begin
					if (final_byte) begin
						error_q <= 1'b1;
					end else begin
						high_q    <= body_byte[6:0];
						pending_q <= 1'b1;
					end
				end else if (bad_idx) begin
					error_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else if (in_ready) begin
			stage_s1.valid <= push;
			stage_s1.op    <= push_op;
			stage_s1.fin   <= final_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[entry_index[prpd_pkg::IDX_W-1:0]] <= {entry_run, entry_code};
		if (push && push_op == prpd_pkg::OP_RUN)
			entry_s1 <= mem[idx[prpd_pkg::IDX_W-1:0]];
	end

	assign stage = stage_s1;
	assign entry = entry_s1;

endmodule

// ===== rtl/prpd_back.sv =====
`timescale 1ns / 1ps

module prpd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  prpd_pkg::stage_t                    stage,
	input  prpd_pkg::entry_t                    entry,
	output logic                                stage_ready,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                result_kind,
	output logic [23:0]                         run_color,
	output logic [15:0]                         run_length,
	output logic                                skip_run,
	output logic [31:0]                         start_pixel,
	output logic                                frame_end
);

	logic        valid_q;
	logic        kind_q;
	logic [23:0] color_q;
	logic [15:0] length_q;
	logic        skip_q;
	logic [31:0] start_q;
	logic        fend_q;
	logic [31:0] pos_q;

	logic        out_free;
	logic        advance;
	logic        load;
	logic [23:0] color;

	assign out_free    = !valid_q || out_ready;
	assign stage_ready = out_free || (stage.op == prpd_pkg::OP_START);
	assign advance     = stage.valid && stage_ready;
	assign load        = advance && (stage.op != prpd_pkg::OP_START);
	assign color       = prpd_pkg::color_rom(entry.code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
			if (advance) begin
				unique case (stage.op)
					prpd_pkg::OP_START: pos_q <= '0;
					prpd_pkg::OP_RUN:   pos_q <= pos_q + 32'(entry.run);
					default:            pos_q <= pos_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			start_q <= pos_q;
			fend_q  <= stage.fin;
			if (stage.op == prpd_pkg::OP_RUN) begin
				kind_q   <= prpd_pkg::KIND_RUN;
				color_q  <= color;
				length_q <= entry.run;
				skip_q   <= (color == prpd_pkg::COLOR_SKIP);
			end else begin
				kind_q   <= prpd_pkg::KIND_ERROR;
				color_q  <= '0;
				length_q <= '0;
				skip_q   <= 1'b0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign result_kind = kind_q;
	assign run_color   = color_q;
	assign run_length  = length_q;
	assign skip_run    = skip_q;
	assign start_pixel = start_q;
	assign frame_end   = fend_q;

endmodule

// ===== rtl/palette_run_length_pixel_decoder.sv =====
`timescale 1ns / 1ps

// palette run-length pixel decoder: takes one input word per cycle with no bubbles as long as
// the result side keeps up. a body word reads the palette memory at the edge it is accepted;
// the colour rom lookup and the pixel position add then load the output register once it has
// room, so a run passes the front stage register and then the output register. palette writes,
// start-frame words and the high byte of a two-byte index give no result. a palette entry
// written by one word is seen by any later word. the palette needs no clearing after reset;
// reading an entry that was never written gives an unspecified run and colour. palette_size is
// written through cfg_wen and cfg_wdata and should only change while no word is in flight.

module palette_run_length_pixel_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// entry_index, entry_run, entry_code, body_byte, zero pad
	input  logic [prpd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// req_type
	input  logic [1:0]                          s_axis_tuser,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// run_color, run_length, start_pixel
	output logic [prpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// result_kind, skip_run
	output logic [1:0]                          m_axis_tuser,
	output logic                                m_axis_tlast,
	input  logic                                cfg_wen,
	input  logic [12:0]                         cfg_wdata
);

	logic [12:0]      palette_size_q;
	prpd_pkg::stage_t stage;
	prpd_pkg::entry_t entry;
	logic             stage_ready;
	logic             result_kind;
	logic [23:0]      run_color;
	logic [15:0]      run_length;
	logic             skip_run;
	logic [31:0]      start_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			palette_size_q <= '0;
		else if (cfg_wen)
			palette_size_q <= cfg_wdata;
	end

	prpd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.req_type     (s_axis_tuser),
		.entry_index  (s_axis_tdata[11:0]),
		.entry_run    (s_axis_tdata[27:12]),
		.entry_code   (s_axis_tdata[35:28]),
		.body_byte    (s_axis_tdata[43:36]),
		.final_byte   (s_axis_tlast),
		.palette_size (palette_size_q),
		.stage_ready  (stage_ready),
		.stage        (stage),
		.entry        (entry)
	);

	prpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage       (stage),
		.entry       (entry),
		.stage_ready (stage_ready),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.result_kind (result_kind),
		.run_color   (run_color),
		.run_length  (run_length),
		.skip_run    (skip_run),
		.start_pixel (start_pixel),
		.frame_end   (m_axis_tlast)
	);

	assign m_axis_tdata = {start_pixel, run_length, run_color};
	assign m_axis_tuser = {skip_run, result_kind};

endmodule
